>>> hw/rtl/temp_sensor_frame_checker_macros.svh
// Assertion macros used by the assertion module of the frame checker.
`ifndef TEMP_SENSOR_FRAME_CHECKER_MACROS_SVH
`define TEMP_SENSOR_FRAME_CHECKER_MACROS_SVH

// A property that must hold in the same cycle as its trigger.
`define TSFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A property that must hold in the cycle after its trigger.
`define TSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tsfc_pkg.sv
package tsfc_pkg;

  // Reflected Maxim CRC-8 polynomial.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // High byte bits that mark a negative reading.
  localparam logic [7:0] SIGN_MASK = 8'hF8;

  // Raw reading of +85 degrees, the sensor's power-on default.
  localparam logic [15:0] POWER_ON_RAW = 16'h0550;

  // Frame position counter.
  localparam int unsigned COUNT_W = 4;
  localparam logic [COUNT_W-1:0] FIRST_AFTER_START = 4'd1;
  localparam logic [COUNT_W-1:0] FRAME_LAST = 4'd8;
  localparam logic [COUNT_W-1:0] IDLE_COUNT = 4'd9;

  // Result field width.
  localparam int unsigned TEMP_W = 18;

  // CRC check outcome.
  typedef enum logic {
    STATUS_CRC_GOOD = 1'b0,
    STATUS_CRC_BAD  = 1'b1
  } status_t;

endpackage

>>> hw/rtl/temp_sensor_frame_checker.sv
// Scratchpad frame checker for a one-wire temperature sensor.
// Input channel (in_valid/in_ready): one received scratchpad byte per transfer,
// with in_frame_start high on byte 0 of a frame. Byte 0 always opens a new
// frame; bytes with in_frame_start low while no frame is open are dropped.
// Result channel (out_valid/out_ready): one transfer per complete frame,
// made on byte 8: signed temperature in 1/16 degree minus the offset, a sign
// flag, the CRC status and a flag for the +85 degree power-on reading.
// Configuration (cfg_valid/cfg_ready): writes the offset in whole degrees;
// always ready; by the user's rule it is written only while the block is
// idle, which the block itself does not enforce. Byte 8 goes through the
// input register, then the result register. Throughput: one byte per cycle,
// unless the result register stalls, set by the byte-wide CRC between them.
// A stalled result register holds its transfer; the input register then
// keeps the byte it holds, so in_ready drops once that register is full
// and stays low until the result is taken.
// Reset clears the CRC, the stored bytes and the offset, and leaves the
// block idle, waiting for a frame start.
module temp_sensor_frame_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tsfc_pkg::TEMP_W-1:0] out_temperature_sixteenths,
  output logic                              out_negative,
  output logic                              out_status,
  output logic                              out_power_on_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        cfg_offset_degrees
);
  import tsfc_pkg::*;

  // Input register.
  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  logic                s1_start_r;
  logic                s1_adv;

  // Frame state.
  logic [7:0]          crc_r, crc_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [7:0]          low_r, low_nxt;
  logic [7:0]          high_r, high_nxt;
  logic [7:0]          offset_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] temp_r;
  logic                neg_r;
  status_t             status_r;
  logic                pov_r;

  logic [7:0]          crc_seed;
  logic [7:0]          crc_step_out;
  logic                frame_open;
  logic                emit;
  logic [15:0]         raw;
  logic                neg;
  logic [TEMP_W-1:0]   reading;
  logic [TEMP_W-1:0]   offset_ext;
  logic [TEMP_W-1:0]   value;

  // The input register moves on only while the result register is free or being emptied.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
  end

  // Byte-wide CRC, restarted from zero on a frame start.
  assign crc_seed = s1_start_r ? 8'h00 : crc_r;

  tsfc_crc8 u_crc8 (
    .crc_in  (crc_seed),
    .data_in (s1_byte_r),
    .crc_out (crc_step_out)
  );

  assign frame_open = (count_r >= FIRST_AFTER_START) && (count_r < FRAME_LAST);
  assign emit       = !s1_start_r && (count_r == FRAME_LAST);

  // Frame state update for the byte in the input register.
  always_comb begin
    crc_nxt   = crc_r;
    count_nxt = count_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    if (s1_adv) begin
      priority if (s1_start_r) begin
        crc_nxt   = crc_step_out;
        low_nxt   = s1_byte_r;
        count_nxt = FIRST_AFTER_START;
      end else if (frame_open) begin
        if (count_r == FIRST_AFTER_START) begin
          high_nxt = s1_byte_r;
        end
        crc_nxt   = crc_step_out;
        count_nxt = count_r + 1'b1;
      end else if (emit) begin
        count_nxt = IDLE_COUNT;
      end else begin
        // No frame is open: the byte is dropped and the state stays put.
        count_nxt = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= 8'h00;
      count_r  <= IDLE_COUNT;
      low_r    <= 8'h00;
      high_r   <= 8'h00;
      offset_r <= 8'h00;
    end else begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      if (cfg_valid && cfg_ready) begin
        offset_r <= cfg_offset_degrees;
      end
    end
  end

  // Signed reading: the raw word sign-extended from the top of the high byte.
  assign raw        = {high_r, low_r};
  assign neg        = (high_r & SIGN_MASK) != 8'h00;
  assign reading    = {neg ? 2'b11 : 2'b00, raw};
  assign offset_ext = {{(TEMP_W-12){1'b0}}, offset_r, 4'b0000};
  assign value      = reading - offset_ext;

  // Result register handshake.
  always_comb begin
    if (s1_adv && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      temp_r   <= signed'(value);
      neg_r    <= neg;
      status_r <= (crc_r != s1_byte_r) ? STATUS_CRC_BAD : STATUS_CRC_GOOD;
      pov_r    <= !neg && (raw == POWER_ON_RAW);
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_temperature_sixteenths = temp_r;
  assign out_negative               = neg_r;
  assign out_status                 = status_r;
  assign out_power_on_value         = pov_r;

endmodule

>>> hw/rtl/tsfc_crc8.sv
module tsfc_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);
  import tsfc_pkg::*;

  // One byte of the reflected CRC, least significant bit first.
  always_comb begin
    logic [7:0] crc;
    logic [7:0] data;
    logic       fb;
    crc  = crc_in;
    data = data_in;
    for (int i = 0; i < 8; i++) begin
      fb   = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      data = data >> 1;
    end
    crc_out = crc;
  end

endmodule

>>> hw/rtl/tsfc_sva.sv
`include "temp_sensor_frame_checker_macros.svh"

module tsfc_sva (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tsfc_pkg::TEMP_W-1:0] out_temperature_sixteenths,
  input logic                              out_negative,
  input logic                              out_status,
  input logic                              out_power_on_value
);
  import tsfc_pkg::*;

  // A stalled result transfer stays valid and keeps its temperature and CRC status.
  `TSFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_temperature_sixteenths) && $stable(out_status), "result changed while stalled")

  // A negative reading minus a non-negative offset stays negative.
  `TSFC_ASSERT_SAME(a_neg_sign, clk, rst_n, out_valid && out_negative, out_temperature_sixteenths[TEMP_W-1], "negative flag with non-negative temperature")

  // The power-on pattern is a positive reading.
  `TSFC_ASSERT_SAME(a_pov_pos, clk, rst_n, out_valid && out_power_on_value, !out_negative, "power-on flag on a negative reading")

endmodule

bind temp_sensor_frame_checker tsfc_sva u_tsfc_sva (
  .clk                        (clk),
  .rst_n                      (rst_n),
  .out_valid                  (out_valid),
  .out_ready                  (out_ready),
  .out_temperature_sixteenths (out_temperature_sixteenths),
  .out_negative               (out_negative),
  .out_status                 (out_status),
  .out_power_on_value         (out_power_on_value)
);

>>> tb/frame_reading_checker.sv
`timescale 1ns / 1ps
module frame_reading_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              in_frame_start,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [tsfc_pkg::TEMP_W-1:0] out_temperature_sixteenths,
  input  logic                              out_negative,
  input  logic                              out_status,
  input  logic                              out_power_on_value,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [7:0]                        cfg_offset_degrees,
  output int unsigned                       mismatches,
  output int unsigned                       outstanding,
  output int unsigned                       readings_checked,
  output int unsigned                       crc_errors_seen,
  output int unsigned                       negatives_seen,
  output int unsigned                       power_on_seen
);
  import tsfc_pkg::*;

  // One expected temperature reading, as the block should report it.
  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     negative;
    status_t                  status;
    logic                     power_on;
  } reading_t;

  // Frame tracking state and the offset register, kept beside the block.
  logic [7:0]         crc_acc;
  logic [COUNT_W-1:0] frame_pos;
  logic [7:0]         low_q;
  logic [7:0]         high_q;
  logic [7:0]         offset_q;
  reading_t           pending_readings[$];

  // Reflected CRC-8 with the Maxim polynomial, one data byte, LSB first.
  function automatic logic [7:0] crc8_maxim_byte(input logic [7:0] crc,
                                                 input logic [7:0] data);
    logic fb;
    int   i;
    for (i = 0; i < 8; i++) begin
      fb   = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reading_t       want;
    reading_t       got_want;
    logic [15:0]    raw;
    int             reading;
    if (!rst_n) begin
      crc_acc          = '0;
      frame_pos        = IDLE_COUNT;
      low_q            = '0;
      high_q           = '0;
      offset_q         = '0;
      pending_readings.delete();
      mismatches       = 0;
      readings_checked = 0;
      crc_errors_seen  = 0;
      negatives_seen   = 0;
      power_on_seen    = 0;
    end else begin
      // Result transfers are compared first; they always belong to older frames.
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: result with no frame pending, actual temperature %0d",
                   $time, out_temperature_sixteenths);
          mismatches++;
        end else begin
          got_want = pending_readings.pop_front();
          readings_checked++;
          if (got_want.status == STATUS_CRC_BAD) crc_errors_seen++;
          if (got_want.negative) negatives_seen++;
          if (got_want.power_on) power_on_seen++;
          if (out_temperature_sixteenths !== got_want.temp) begin
            report_field("temperature_sixteenths", got_want.temp,
                         out_temperature_sixteenths);
          end
          if (out_negative !== got_want.negative) begin
            report_field("negative", got_want.negative, out_negative);
          end
          if (out_status !== got_want.status) begin
            report_field("status", got_want.status, out_status);
          end
          if (out_power_on_value !== got_want.power_on) begin
            report_field("power_on_value", got_want.power_on, out_power_on_value);
          end
        end
      end

      // The offset register only changes while no frame result is due.
      if (cfg_valid && cfg_ready) begin
        offset_q = cfg_offset_degrees;
      end

      // Track the frame position and work out the reading on the CRC byte.
      if (in_valid && in_ready) begin
        if (in_frame_start) begin
          crc_acc   = crc8_maxim_byte(8'h00, in_rx_byte);
          low_q     = in_rx_byte;
          frame_pos = FIRST_AFTER_START;
        end else if (frame_pos >= IDLE_COUNT || frame_pos == '0) begin
          // No frame open: the byte is dropped.
        end else if (frame_pos < FRAME_LAST) begin
          if (frame_pos == FIRST_AFTER_START) begin
            high_q = in_rx_byte;
          end
          crc_acc   = crc8_maxim_byte(crc_acc, in_rx_byte);
          frame_pos = frame_pos + 1'b1;
        end else begin
          raw           = {high_q, low_q};
          want.negative = |(high_q & SIGN_MASK);
          reading       = int'(raw);
          if (want.negative) begin
            reading -= 65536;
          end
          reading      -= 16 * int'(offset_q);
          want.temp     = reading[TEMP_W-1:0];
          want.status   = (crc_acc == in_rx_byte) ? STATUS_CRC_GOOD : STATUS_CRC_BAD;
          want.power_on = !want.negative && (raw == POWER_ON_RAW);
          pending_readings.push_back(want);
          frame_pos = IDLE_COUNT;
        end
      end
    end
    outstanding <= pending_readings.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import tsfc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 6;
  localparam int unsigned PHASE_ITEMS      = 315;
  localparam int unsigned NUM_PHASES       = 6;

  // Notable raw readings.
  localparam logic [15:0] MINUS_85_RAW     = 16'hFAB0;
  localparam logic [15:0] MAX_POSITIVE_RAW = 16'h07FF;
  localparam logic [15:0] MIN_NEGATIVE_RAW = 16'h0800;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE_STALL
  } rx_pattern_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                in_rx_byte;
  logic                      in_frame_start;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [TEMP_W-1:0]  out_temperature_sixteenths;
  logic                      out_negative;
  logic                      out_status;
  logic                      out_power_on_value;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [7:0]                cfg_offset_degrees;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned readings_checked;
  int unsigned crc_errors_seen;
  int unsigned negatives_seen;
  int unsigned power_on_seen;

  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles = 0;
  logic        hold_req;

  temp_sensor_frame_checker dut (.*);

  frame_reading_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus-side CRC, used to build frames with a correct check byte.
  function automatic logic [7:0] frame_crc_step(input logic [7:0] crc,
                                                input logic [7:0] data);
    logic fb;
    int   i;
    for (i = 0; i < 8; i++) begin
      fb   = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

  // Mix of special readings, realistic sensor values and arbitrary patterns.
  function automatic logic [15:0] pick_reading();
    case ($urandom_range(0, 9))
      0:       return POWER_ON_RAW;
      1:       return MINUS_85_RAW;
      2:       return MAX_POSITIVE_RAW;
      3:       return MIN_NEGATIVE_RAW;
      4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      5, 6:    return 16'($urandom_range(0, 2880)) - 16'd880;
      default: return 16'($urandom);
    endcase
  endfunction

  // One input transfer; bursts of random length with random gaps between.
  task automatic send_item(input logic [7:0] value, input logic start, input bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(8, 20);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= value;
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (counted) bytes_sent++;
  endtask

  // A full nine-byte scratchpad frame carrying the given raw reading.
  task automatic send_frame(input logic [15:0] raw, input bit bad_crc);
    logic [7:0] frame [0:8];
    logic [7:0] crc;
    int         i;
    frame[0] = raw[7:0];
    frame[1] = raw[15:8];
    for (i = 2; i < 8; i++) frame[i] = 8'($urandom);
    crc = 8'h00;
    for (i = 0; i < 8; i++) crc = frame_crc_step(crc, frame[i]);
    frame[8] = bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc;
    for (i = 0; i < 9; i++) send_item(frame[i], i == 0, 1'b1);
  endtask

  // A frame cut short after the given number of bytes.
  task automatic send_partial(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_item(8'($urandom), i == 0, 1'b1);
  endtask

  // Stop offering bytes and wait until every reading is back and the block is quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main stimulus: directed frames, then random traffic over several offsets.
  initial begin
    logic [7:0]  offsets [0:NUM_PHASES-1];
    int unsigned phase;
    int unsigned phase_end;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_rx_byte         <= '0;
    in_frame_start     <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_offset_degrees <= '0;
    hold_req           <= 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    offsets[0] = 8'd255;
    offsets[1] = 8'd0;
    offsets[2] = 8'd1;
    offsets[3] = 8'($urandom_range(2, 254));
    offsets[4] = 8'd128;
    offsets[5] = 8'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A stray byte while idle, a frame restarted mid-way, the power-on
    // reading, and minus 85 degrees with a broken check byte.
    send_item(8'hA5, 1'b0, 1'b0);
    send_partial(3);
    send_frame(POWER_ON_RAW, 1'b0);
    send_frame(MINUS_85_RAW, 1'b1);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      cfg_valid          <= 1'b1;
      cfg_offset_degrees <= offsets[phase];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid  <= 1'b0;
      // The long receiver hold-off lands while the first phase keeps offering bytes.
      if (phase == 0) hold_req <= 1'b1;
      burst_left = 0;
      phase_end  = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) begin
        case ($urandom_range(0, 19))
          0:       repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, 1'b0);
          1:       send_partial($urandom_range(1, 8));
          2:       repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'($urandom), 1'b1);
          3, 4:    send_frame(pick_reading(), 1'b1);
          default: send_frame(pick_reading(), 1'b0);
        endcase
      end
    end

    wait_drained();
    $display("Drove %0d bytes under %0d offsets, with restarts, cut frames and idle noise.",
             bytes_sent, NUM_PHASES + 1);
    $display("Compared %0d readings: %0d with CRC errors, %0d negative, %0d power-on.",
             readings_checked, crc_errors_seen, negatives_seen, power_on_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: stall patterns of its own, plus one long hold-off.
  initial begin
    rx_pattern_t pattern;
    int          span;
    int          k;
    bit          held;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      pattern = rx_pattern_t'($urandom_range(0, 3));
      span    = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        case (pattern)
          RX_ALWAYS:        out_ready <= 1'b1;
          RX_COIN:          out_ready <= 1'($urandom);
          RX_THREE_OF_FOUR: out_ready <= (k % 4 != 3);
          RX_SPARSE_STALL:  out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d readings still due",
               $time, quiet_cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tsfc_pkg.sv
hw/rtl/tsfc_crc8.sv
hw/rtl/temp_sensor_frame_checker.sv
hw/rtl/tsfc_sva.sv
tb/frame_reading_checker.sv
tb/tb.sv
